// ===== rtl/tfvc_pkg.sv =====
package tfvc_pkg;

    // Field widths
    localparam int POSITION_BITS      = 16;
    localparam int LABEL_BITS         = 8;
    localparam int GAIN_FRACTION_BITS = 12;

    localparam int WANTED_W   = LABEL_BITS + 1;
    localparam int CFG_DATA_W = (WANTED_W > 16) ? WANTED_W : 16;
    localparam int CFG_IDX_W  = 3;

    // Forward error: signed position minus a 15-bit standoff
    localparam int ERR_W  = ((POSITION_BITS > 15) ? POSITION_BITS : 16) + 1;
    // Signed product of the error and a 17-bit signed view of a gain
    localparam int PROD_W = ERR_W + 17;

    // Label filter value that accepts any class
    localparam logic [WANTED_W-1:0] ANY_LABEL = WANTED_W'(1) << LABEL_BITS;

    // Register reset values
    localparam logic                 RST_FOLLOW_ENABLE = 1'b1;
    localparam logic [WANTED_W-1:0]  RST_WANTED_LABEL  = ANY_LABEL;
    localparam logic [14:0]          RST_STANDOFF      = 15'd1000;
    localparam logic [15:0]          RST_FORWARD_GAIN  = 16'd2458;
    localparam logic [15:0]          RST_TURN_GAIN     = 16'd4915;
    localparam logic [14:0]          RST_FORWARD_LIMIT = 15'd400;
    localparam logic [14:0]          RST_TURN_LIMIT    = 15'd800;
    localparam logic [15:0]          RST_STALE_AFTER   = 16'd500;

    typedef enum logic [1:0] {
        ACT_DETECT  = 2'd0,
        ACT_STATUS  = 2'd1,
        ACT_PUBLISH = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOLLOW_ENABLE = 3'd0,
        REG_WANTED_LABEL  = 3'd1,
        REG_STANDOFF      = 3'd2,
        REG_FORWARD_GAIN  = 3'd3,
        REG_TURN_GAIN     = 3'd4,
        REG_FORWARD_LIMIT = 3'd5,
        REG_TURN_LIMIT    = 3'd6,
        REG_STALE_AFTER   = 3'd7
    } t_reg_index;

    typedef enum logic [1:0] {
        FS_DISABLED = 2'd0,
        FS_BLOCKED  = 2'd1,
        FS_WAITING  = 2'd2,
        FS_TRACKING = 2'd3
    } t_follow_state;

    typedef struct packed {
        logic [1:0]                      action;
        logic                            object_present;
        logic                            has_position;
        logic [LABEL_BITS-1:0]           object_label;
        logic [15:0]                     confidence;
        logic signed [POSITION_BITS-1:0] lateral_mm;
        logic signed [POSITION_BITS-1:0] forward_mm;
        logic                            frame_last;
        logic [31:0]                     time_ms;
        logic                            mode_tracking;
        logic                            ai_on;
        logic                            fault_or_estop;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0]    linear_speed;
        logic signed [15:0]    angular_speed;
        logic [1:0]            follow_state;
        logic [LABEL_BITS-1:0] followed_label;
    } t_out_item;

    typedef struct packed {
        logic                follow_enable;
        logic [WANTED_W-1:0] wanted_label;
        logic [14:0]         standoff_distance_mm;
        logic [15:0]         forward_gain;
        logic [15:0]         turn_gain;
        logic [14:0]         forward_speed_limit;
        logic [14:0]         turn_speed_limit;
        logic [15:0]         stale_after_ms;
    } t_cfg;

    // Target and permission state seen by the command logic
    typedef struct packed {
        logic                            target_valid;
        logic signed [POSITION_BITS-1:0] target_x;
        logic signed [POSITION_BITS-1:0] target_z;
        logic [LABEL_BITS-1:0]           target_class;
        logic [31:0]                     target_time;
        logic                            status_seen;
        logic                            command_allowed;
    } t_track;

    // Scale a Q product down, round half away from zero, clamp to +-limit
    function automatic logic signed [15:0] scale_clamp(
        input logic signed [PROD_W-1:0] prod,
        input logic [14:0]              limit
    );
        logic                             neg;
        logic [PROD_W-1:0]                mag;
        logic [PROD_W:0]                  rnd;
        logic [PROD_W-GAIN_FRACTION_BITS:0] r;
        logic [14:0]                      sat;
        logic [15:0]                      ext;
        neg = prod[PROD_W-1];
        mag = neg ? PROD_W'(-prod) : PROD_W'(prod);
        rnd = {1'b0, mag} + ((PROD_W + 1)'(1) << (GAIN_FRACTION_BITS - 1));
        r   = rnd[PROD_W:GAIN_FRACTION_BITS];
        if (r > (PROD_W - GAIN_FRACTION_BITS + 1)'(limit)) begin
            sat = limit;
        end else begin
            sat = r[14:0];
        end
        ext = {1'b0, sat};
        return neg ? $signed(16'(-ext)) : $signed(ext);
    endfunction

endpackage

// ===== rtl/tfvc_tracker.sv =====
module tfvc_tracker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fire,
    input  tfvc_pkg::t_in_item                  i_item,
    input  logic [tfvc_pkg::WANTED_W-1:0]       i_wanted_label,
    output tfvc_pkg::t_track                    o_track
);
    import tfvc_pkg::*;

    // frame accumulator
    logic                            r_found;
    logic [15:0]                     r_best_conf;
    logic signed [POSITION_BITS-1:0] r_best_x;
    logic signed [POSITION_BITS-1:0] r_best_z;
    logic [LABEL_BITS-1:0]           r_best_label;
    // target and permission
    logic                            r_tgt_valid;
    logic signed [POSITION_BITS-1:0] r_tgt_x;
    logic signed [POSITION_BITS-1:0] r_tgt_z;
    logic [LABEL_BITS-1:0]           r_tgt_class;
    logic [31:0]                     r_tgt_time;
    logic                            r_status_seen;
    logic                            r_cmd_allowed;

    logic is_detect;
    logic is_status;
    logic label_ok;
    logic qualifies;
    logic take;
    logic n_found;
    logic signed [POSITION_BITS-1:0] n_best_x;
    logic signed [POSITION_BITS-1:0] n_best_z;
    logic [LABEL_BITS-1:0]           n_best_label;

    // object filter and best-so-far compare
    always_comb begin
        is_detect = i_fire && (t_action'(i_item.action) == ACT_DETECT);
        is_status = i_fire && (t_action'(i_item.action) == ACT_STATUS);
        label_ok  = (i_wanted_label == ANY_LABEL) ||
                    (i_wanted_label == {1'b0, i_item.object_label});
        qualifies = i_item.object_present && i_item.has_position && label_ok;
        take      = is_detect && qualifies &&
                    (!r_found || (i_item.confidence > r_best_conf));
        n_found      = r_found || take;
        n_best_x     = take ? i_item.lateral_mm   : r_best_x;
        n_best_z     = take ? i_item.forward_mm   : r_best_z;
        n_best_label = take ? i_item.object_label : r_best_label;
    end

    // accumulator payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_conf  <= i_item.confidence;
            r_best_x     <= i_item.lateral_mm;
            r_best_z     <= i_item.forward_mm;
            r_best_label <= i_item.object_label;
        end
    end

    // frame close moves the winner into the target
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found       <= 1'b0;
            r_tgt_valid   <= 1'b0;
            r_status_seen <= 1'b0;
            r_cmd_allowed <= 1'b0;
        end else begin
            if (is_detect && i_item.frame_last) begin
                r_found     <= 1'b0;
                r_tgt_valid <= n_found;
            end else if (take) begin
                r_found <= 1'b1;
            end
            if (is_status) begin
                r_status_seen <= 1'b1;
                r_cmd_allowed <= i_item.mode_tracking && i_item.ai_on &&
                                 !i_item.fault_or_estop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_detect && i_item.frame_last && n_found) begin
            r_tgt_x     <= n_best_x;
            r_tgt_z     <= n_best_z;
            r_tgt_class <= n_best_label;
            r_tgt_time  <= i_item.time_ms;
        end
    end

    always_comb begin
        o_track.target_valid    = r_tgt_valid;
        o_track.target_x        = r_tgt_x;
        o_track.target_z        = r_tgt_z;
        o_track.target_class    = r_tgt_class;
        o_track.target_time     = r_tgt_time;
        o_track.status_seen     = r_status_seen;
        o_track.command_allowed = r_cmd_allowed;
    end

endmodule

// ===== rtl/tfvc_command.sv =====
module tfvc_command (
    input  tfvc_pkg::t_cfg      i_cfg,
    input  tfvc_pkg::t_track    i_track,
    input  logic [31:0]         i_time_ms,
    output tfvc_pkg::t_out_item o_result
);
    import tfvc_pkg::*;

    logic [31:0]              age;
    logic                     fresh;
    t_follow_state            state;
    logic signed [ERR_W-1:0]  ferr;
    logic signed [PROD_W-1:0] lin_prod;
    logic signed [PROD_W-1:0] ang_prod;

    // state decision
    always_comb begin
        age   = i_time_ms - i_track.target_time;
        fresh = i_track.target_valid && (age <= {16'd0, i_cfg.stale_after_ms});
        if (!i_cfg.follow_enable) begin
            state = FS_DISABLED;
        end else if (!i_track.status_seen || !i_track.command_allowed) begin
            state = FS_BLOCKED;
        end else if (!fresh) begin
            state = FS_WAITING;
        end else begin
            state = FS_TRACKING;
        end
    end

    // proportional terms
    always_comb begin
        ferr     = ERR_W'(i_track.target_z) -
                   $signed({{(ERR_W - 15){1'b0}}, i_cfg.standoff_distance_mm});
        lin_prod = PROD_W'(ferr) * $signed({{(PROD_W - 16){1'b0}}, i_cfg.forward_gain});
        ang_prod = -(PROD_W'(i_track.target_x) *
                     $signed({{(PROD_W - 16){1'b0}}, i_cfg.turn_gain}));
    end

    // result, zero outside tracking
    always_comb begin
        o_result.follow_state = state;
        if (state == FS_TRACKING) begin
            o_result.linear_speed   = scale_clamp(lin_prod, i_cfg.forward_speed_limit);
            o_result.angular_speed  = scale_clamp(ang_prod, i_cfg.turn_speed_limit);
            o_result.followed_label = i_track.target_class;
        end else begin
            o_result.linear_speed   = '0;
            o_result.angular_speed  = '0;
            o_result.followed_label = '0;
        end
    end

endmodule

// ===== rtl/target_follow_velocity_controller.sv =====
// Channel   Direction  Handshake              Payload
// in        input      i_in_valid/o_in_stall   i_in  (t_in_item)
// out       output     o_out_valid/i_out_stall o_out (t_out_item, publish only)
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One request per cycle while the input is not stalled. A request waits in the
// input register until it fires and updates the tracker; a publish that fires
// lands in the output register. The input stalls only while a publish waits in
// the input register and the output register holds a result that is itself
// stalled. Synchronous active-low reset restores register defaults and clears
// valid and tracker flags.
module target_follow_velocity_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tfvc_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output tfvc_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tfvc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tfvc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tfvc_pkg::*;

    t_cfg      r_cfg;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;

    logic      is_publish;
    logic      fire;
    logic      in_take;
    t_track    track;
    t_out_item result;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.follow_enable        <= RST_FOLLOW_ENABLE;
            r_cfg.wanted_label         <= RST_WANTED_LABEL;
            r_cfg.standoff_distance_mm <= RST_STANDOFF;
            r_cfg.forward_gain         <= RST_FORWARD_GAIN;
            r_cfg.turn_gain            <= RST_TURN_GAIN;
            r_cfg.forward_speed_limit  <= RST_FORWARD_LIMIT;
            r_cfg.turn_speed_limit     <= RST_TURN_LIMIT;
            r_cfg.stale_after_ms       <= RST_STALE_AFTER;
        end else if (i_cfg_valid) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_FOLLOW_ENABLE: r_cfg.follow_enable        <= i_cfg_data[0];
                REG_WANTED_LABEL:  r_cfg.wanted_label         <= i_cfg_data[WANTED_W-1:0];
                REG_STANDOFF:      r_cfg.standoff_distance_mm <= i_cfg_data[14:0];
                REG_FORWARD_GAIN:  r_cfg.forward_gain         <= i_cfg_data[15:0];
                REG_TURN_GAIN:     r_cfg.turn_gain            <= i_cfg_data[15:0];
                REG_FORWARD_LIMIT: r_cfg.forward_speed_limit  <= i_cfg_data[14:0];
                REG_TURN_LIMIT:    r_cfg.turn_speed_limit     <= i_cfg_data[14:0];
                REG_STALE_AFTER:   r_cfg.stale_after_ms       <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // flow control: only a publish needs room in the output register
    always_comb begin
        is_publish = t_action'(r_in.action) == ACT_PUBLISH;
        fire       = r_in_valid && (!is_publish || !r_out_valid || !i_out_stall);
        o_in_stall = r_in_valid && !fire;
        in_take    = i_in_valid && !o_in_stall;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in;
        end
    end

    tfvc_tracker u_tracker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_item         (r_in),
        .i_wanted_label (r_cfg.wanted_label),
        .o_track        (track)
    );

    tfvc_command u_command (
        .i_cfg     (r_cfg),
        .i_track   (track),
        .i_time_ms (r_in.time_ms),
        .o_result  (result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && is_publish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && is_publish) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a publish that fires always shows a result next cycle
    a_publish_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && is_publish |=> r_out_valid)
        else $error("publish request lost");

    // detection and status requests never hold up the input
    a_no_stall_non_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !is_publish |-> !o_in_stall)
        else $error("non-publish request stalled");

    // outside tracking the command is a full stop with no label
    a_stop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (t_follow_state'(r_out.follow_state) != FS_TRACKING) |->
        (r_out.linear_speed == '0) && (r_out.angular_speed == '0) &&
        (r_out.followed_label == '0))
        else $error("nonzero command outside tracking");

    // a held result is not overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !(fire && is_publish))
        else $error("stalled result overwritten");

endmodule
